### sv/store_to_load_forward_table_defines.svh
// ----------------------------------------------------------------------------
// Store-to-load forwarding table: assertion macros
// Shared concurrent assertion wrappers for the controller and datapath.
// ----------------------------------------------------------------------------
`ifndef STORE_TO_LOAD_FORWARD_TABLE_DEFINES_SVH
`define STORE_TO_LOAD_FORWARD_TABLE_DEFINES_SVH

// Check a property on every rising edge, ignored while reset is held.
`define STLF_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define STLF_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/stlf_pkg.sv
// ----------------------------------------------------------------------------
// Store-to-load forwarding table: package
// Instruction kinds, controller states and the command word.
// ----------------------------------------------------------------------------
package stlf_pkg;

  localparam int KIND_BITS = 2;
  localparam int SIZE_BITS = 2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_STORE = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_REDEF = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;  // latch the incoming word
    logic search;   // compare against every entry, register the masks
    logic commit;   // compact, insert and load the result register
  } cmd_t;

endpackage

### sv/stlf_ctrl.sv
// ----------------------------------------------------------------------------
// Store-to-load forwarding table: controller
// Sequences capture, search and commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
`include "store_to_load_forward_table_defines.svh"

module stlf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output stlf_pkg::cmd_t cmd
);

  stlf_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stlf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      stlf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = stlf_pkg::ST_SEARCH;
        end
      end
      stlf_pkg::ST_SEARCH: begin
        cmd.search = 1'b1;
        state_nxt  = stlf_pkg::ST_UPDATE;
      end
      stlf_pkg::ST_UPDATE: begin
        // hold until the result register is free or being emptied
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = stlf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stlf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  `STLF_ASSERT(a_commit_free, clk, rst_n, cmd.commit |-> (!out_valid_r || out_tready), "commit overwrote a pending result")
  `STLF_ASSERT(a_search_then_update, clk, rst_n, cmd.search |=> (state_r == stlf_pkg::ST_UPDATE), "search not followed by update")
  `STLF_ASSERT_ALWAYS(a_one_cmd, clk, $onehot0({cmd.capture, cmd.search, cmd.commit}), "more than one command at once")

endmodule

### sv/stlf_dp.sv
// ----------------------------------------------------------------------------
// Store-to-load forwarding table: datapath
// Entry table, parallel compare, compaction with insert, result register.
// ----------------------------------------------------------------------------
`include "store_to_load_forward_table_defines.svh"

module stlf_dp #(
  parameter int TABLE_DEPTH = 8,
  parameter int REG_BITS    = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  stlf_pkg::cmd_t         cmd,
  input  stlf_pkg::kind_t        kind,
  input  logic                   claimed,
  input  logic [REG_BITS-1:0]    reg_a,
  input  logic                   reg_a_valid,
  input  logic [REG_BITS-1:0]    base_reg,
  input  logic                   base_valid,
  input  logic [stlf_pkg::SIZE_BITS-1:0] size_code,
  input  logic [OFFSET_BITS-1:0] offset,
  output logic                   forwarded,
  output logic [REG_BITS-1:0]    forward_src
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [REG_BITS-1:0]              base;
    logic                             base_ok;
    logic [REG_BITS-1:0]              value_reg;
    logic                             value_ok;
    logic [stlf_pkg::SIZE_BITS-1:0]   size;
    logic [OFFSET_BITS-1:0]           off;
  } entry_t;

  // [a, a + 2^sa) lies wholly below b, no wrap
  function automatic logic below(input logic [OFFSET_BITS-1:0] a,
                                 input logic [stlf_pkg::SIZE_BITS-1:0] sa,
                                 input logic [OFFSET_BITS-1:0] b);
    logic [OFFSET_BITS:0] a_end;
    a_end = {1'b0, a} + ((OFFSET_BITS+1)'(1) << sa);
    return a_end <= {1'b0, b};
  endfunction

  // captured word
  stlf_pkg::kind_t item_kind_r;
  logic            item_claimed_r;
  entry_t          item_r;

  entry_t             tbl_r   [TABLE_DEPTH];
  entry_t             tbl_nxt [TABLE_DEPTH];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [TABLE_DEPTH-1:0] keep_r, keep_nxt;
  logic                   ins_r, ins_nxt;
  logic                   fwd_r, fwd_nxt;
  logic [REG_BITS-1:0]    src_r, src_nxt;

  logic                   out_fwd_r;
  logic [REG_BITS-1:0]    out_src_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_kind_r       <= kind;
      item_claimed_r    <= claimed;
      item_r.base       <= base_reg;
      item_r.base_ok    <= base_valid;
      item_r.value_reg  <= reg_a;
      item_r.value_ok   <= reg_a_valid;
      item_r.size       <= size_code;
      item_r.off        <= offset;
    end
  end

  // search: compare every live entry in parallel
  logic [TABLE_DEPTH-1:0] hit, first_hit, naming, live;
  logic                   ra_is_base;

  always_comb begin
    hit      = '0;
    naming   = '0;
    live     = '0;
    keep_nxt = '0;
    src_nxt  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      live[i] = CNT_W'(i) < cnt_r;
      hit[i]  = live[i] && tbl_r[i].base_ok && item_r.base_ok &&
                tbl_r[i].base == item_r.base && tbl_r[i].off == item_r.off &&
                tbl_r[i].size == item_r.size && tbl_r[i].value_ok &&
                !(item_r.value_ok && tbl_r[i].value_reg == item_r.value_reg);
      naming[i] = item_r.value_ok &&
                  ((tbl_r[i].base_ok && tbl_r[i].base == item_r.value_reg) ||
                   (tbl_r[i].value_ok && tbl_r[i].value_reg == item_r.value_reg));
      unique case (item_kind_r)
        stlf_pkg::KIND_LOAD,
        stlf_pkg::KIND_REDEF: keep_nxt[i] = live[i] && !naming[i];
        stlf_pkg::KIND_STORE: keep_nxt[i] = live[i] && tbl_r[i].base_ok &&
            item_r.base_ok && tbl_r[i].base == item_r.base &&
            (below(tbl_r[i].off, tbl_r[i].size, item_r.off) ||
             below(item_r.off, item_r.size, tbl_r[i].off));
        stlf_pkg::KIND_FLUSH: keep_nxt[i] = 1'b0;
        default:              keep_nxt[i] = 1'b0;
      endcase
    end
    // oldest matching entry wins
    first_hit = hit & (~hit + TABLE_DEPTH'(1));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (first_hit[i]) begin
        src_nxt = src_nxt | tbl_r[i].value_reg;
      end
    end
    ra_is_base = item_r.base_ok && item_r.value_ok && item_r.base == item_r.value_reg;
    fwd_nxt    = (item_kind_r == stlf_pkg::KIND_LOAD) && (|hit) && !item_claimed_r;
    if (!fwd_nxt) begin
      src_nxt = '0;
    end
    unique case (item_kind_r)
      stlf_pkg::KIND_LOAD:  ins_nxt = !(|hit) && !item_claimed_r && item_r.base_ok &&
                                      !ra_is_base;
      stlf_pkg::KIND_STORE: ins_nxt = !item_claimed_r;
      stlf_pkg::KIND_FLUSH,
      stlf_pkg::KIND_REDEF: ins_nxt = 1'b0;
      default:              ins_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      keep_r <= keep_nxt;
      ins_r  <= ins_nxt;
      fwd_r  <= fwd_nxt;
      src_r  <= src_nxt;
    end
  end

  // commit: squeeze out dropped entries, then append at the tail
  logic [CNT_W-1:0] pre [TABLE_DEPTH];
  logic [CNT_W-1:0] kcount, ins_pos;
  logic             drop_old;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      pre[i] = '0;
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        if (j < i && keep_r[j]) begin
          pre[i] = pre[i] + CNT_W'(1);
        end
      end
    end
    kcount   = CNT_W'($countones(keep_r));
    // full table on insert: the oldest survivor goes
    drop_old = ins_r && kcount == CNT_W'(TABLE_DEPTH);
    ins_pos  = kcount - CNT_W'(drop_old);
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      tbl_nxt[j] = tbl_r[j];
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (keep_r[i] && pre[i] == CNT_W'(j) + CNT_W'(drop_old)) begin
          tbl_nxt[j] = tbl_r[i];
        end
      end
      if (ins_r && ins_pos == CNT_W'(j)) begin
        tbl_nxt[j] = item_r;
      end
    end
    cnt_nxt = ins_pos + CNT_W'(ins_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        tbl_r[j] <= tbl_nxt[j];
      end
      out_fwd_r <= fwd_r;
      out_src_r <= src_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.commit) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign forwarded   = out_fwd_r;
  assign forward_src = out_src_r;

  `STLF_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
  `STLF_ASSERT(a_flush_empties, clk, rst_n, (cmd.commit && item_kind_r == stlf_pkg::KIND_FLUSH) |=> cnt_r == '0, "flush left entries behind")
  `STLF_ASSERT(a_insert_nonempty, clk, rst_n, (cmd.commit && ins_r) |=> cnt_r != '0, "insert left the table empty")

endmodule

### sv/store_to_load_forward_table.sv
// Each accepted word is captured, searched, then committed to the result word.
// The next input word is taken only after the last one has been committed.
// The compaction pass rewrites the whole entry table at commit.
// A waiting result does not block the next input word from being taken, but
// that word holds in its commit cycle until the waiting result is taken.
// Reset (rst_n low, synchronous) empties the table and clears the controller;
// entry contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
// Store-to-load forwarding table: top level
// Tracks memory slots held in registers and reports loads that can forward.
// ----------------------------------------------------------------------------
module store_to_load_forward_table #(
  parameter int TABLE_DEPTH = 8,
  parameter int REG_BITS    = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // reg_a, reg_a_valid, base_reg, base_valid, size_code, offset, zero pad
  input  logic [((2*REG_BITS+OFFSET_BITS+4+7)/8)*8-1:0] in_tdata,
  // kind, claimed
  input  logic [2:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // forward_src, zero pad
  output logic [((REG_BITS+7)/8)*8-1:0] out_tdata,
  // forwarded
  output logic [0:0] out_tuser
);

  localparam int OUT_DATA_W = ((REG_BITS + 7) / 8) * 8;
  localparam int RAV_POS    = REG_BITS;
  localparam int BASE_LO    = REG_BITS + 1;
  localparam int BV_POS     = 2 * REG_BITS + 1;
  localparam int SIZE_LO    = 2 * REG_BITS + 2;
  localparam int OFF_LO     = 2 * REG_BITS + 4;

  stlf_pkg::cmd_t      cmd;
  logic                forwarded;
  logic [REG_BITS-1:0] forward_src;

  stlf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  stlf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .REG_BITS    (REG_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .kind        (stlf_pkg::kind_t'(in_tuser[1:0])),
    .claimed     (in_tuser[2]),
    .reg_a       (in_tdata[REG_BITS-1:0]),
    .reg_a_valid (in_tdata[RAV_POS]),
    .base_reg    (in_tdata[BASE_LO +: REG_BITS]),
    .base_valid  (in_tdata[BV_POS]),
    .size_code   (in_tdata[SIZE_LO +: stlf_pkg::SIZE_BITS]),
    .offset      (in_tdata[OFF_LO +: OFFSET_BITS]),
    .forwarded   (forwarded),
    .forward_src (forward_src)
  );

  assign out_tdata = OUT_DATA_W'(forward_src);
  assign out_tuser = forwarded;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Store-to-load forwarding table: testbench
// Streams instructions through the table and checks every result word against a slot-table
// predictor kept in step with the accepted input words, or against a directed row's typed result.
// A directed walk over corner cases comes first, then biased random traffic.
// ----------------------------------------------------------------------------
module tb;

  localparam int N_SLOTS      = 8;
  localparam int N_RANDOM     = 1100;
  localparam int N_QUIET      = 150;
  localparam int N_DIRECTED   = 23;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS  = 10;

  localparam bit [1:0] SZ_B1 = 2'd0;
  localparam bit [1:0] SZ_B2 = 2'd1;
  localparam bit [1:0] SZ_B4 = 2'd2;
  localparam bit [1:0] SZ_B8 = 2'd3;

  typedef struct {
    stlf_pkg::kind_t kind;
    bit              claimed;
    bit [15:0]       reg_a;
    bit              reg_a_ok;
    bit [15:0]       base;
    bit              base_ok;
    bit [1:0]        size;
    bit [31:0]       off;
  } instr_t;

  typedef struct {
    bit        fwd;
    bit [15:0] src;
  } fwd_result_t;

  typedef struct {
    instr_t      ins;
    bit          exp_typed;
    fwd_result_t res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;

  store_to_load_forward_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Slot table predictor state
  bit [15:0] slot_base   [N_SLOTS];
  bit        slot_base_ok[N_SLOTS];
  bit [15:0] slot_val    [N_SLOTS];
  bit        slot_val_ok [N_SLOTS];
  bit [1:0]  slot_size   [N_SLOTS];
  bit [31:0] slot_off    [N_SLOTS];
  int        slot_cnt;

  // Recently touched slots, reused so that loads find something to forward
  bit [15:0] rec_base[4];
  bit [1:0]  rec_size[4];
  bit [31:0] rec_off [4];

  fwd_result_t fwd_expect_q[$];
  dir_row_t    dir_rows[N_DIRECTED];
  int          mismatch_cnt;
  int          idle_cycles;
  bit          quiet;
  int          stall_left;

  always #4 clk = ~clk;

  function automatic bit regs_match(bit [15:0] a, bit a_ok, bit [15:0] b, bit b_ok);
    return a_ok && b_ok && (a == b);
  endfunction

  // Byte ranges are compared with headroom so that the top of memory never wraps
  function automatic bit ranges_overlap(bit [31:0] oa, bit [1:0] sa,
                                        bit [31:0] ob, bit [1:0] sb);
    bit [33:0] a, b, na, nb;
    a  = {2'b00, oa};
    b  = {2'b00, ob};
    na = 34'd1 << sa;
    nb = 34'd1 << sb;
    return !((a + na <= b) || (b + nb <= a));
  endfunction

  function automatic void slot_remove(int idx);
    for (int j = idx; j < slot_cnt - 1; j++) begin
      slot_base[j]    = slot_base[j+1];
      slot_base_ok[j] = slot_base_ok[j+1];
      slot_val[j]     = slot_val[j+1];
      slot_val_ok[j]  = slot_val_ok[j+1];
      slot_size[j]    = slot_size[j+1];
      slot_off[j]     = slot_off[j+1];
    end
    slot_cnt--;
  endfunction

  function automatic void slot_drop_reg(bit [15:0] r, bit r_ok);
    int i;
    i = 0;
    while (i < slot_cnt) begin
      if (regs_match(slot_base[i], slot_base_ok[i], r, r_ok) ||
          regs_match(slot_val[i], slot_val_ok[i], r, r_ok))
        slot_remove(i);
      else
        i++;
    end
  endfunction

  // Full table: evict the oldest before appending
  function automatic void slot_insert(instr_t it);
    if (slot_cnt >= N_SLOTS)
      slot_remove(0);
    slot_base[slot_cnt]    = it.base;
    slot_base_ok[slot_cnt] = it.base_ok;
    slot_val[slot_cnt]     = it.reg_a;
    slot_val_ok[slot_cnt]  = it.reg_a_ok;
    slot_size[slot_cnt]    = it.size;
    slot_off[slot_cnt]     = it.off;
    slot_cnt++;
  endfunction

  function automatic fwd_result_t forward_predict(instr_t it);
    fwd_result_t r;
    bit          found;
    int          i;
    r.fwd = 1'b0;
    r.src = '0;
    found = 1'b0;
    case (it.kind)
      stlf_pkg::KIND_LOAD: begin
        for (i = 0; i < slot_cnt && !found; i++) begin
          if (regs_match(slot_base[i], slot_base_ok[i], it.base, it.base_ok) &&
              slot_off[i] == it.off && slot_size[i] == it.size && slot_val_ok[i] &&
              !regs_match(slot_val[i], slot_val_ok[i], it.reg_a, it.reg_a_ok)) begin
            found = 1'b1;
            if (!it.claimed) begin
              r.fwd = 1'b1;
              r.src = slot_val[i];
            end
          end
        end
        slot_drop_reg(it.reg_a, it.reg_a_ok);
        if (!r.fwd && !it.claimed && it.base_ok &&
            !regs_match(it.base, it.base_ok, it.reg_a, it.reg_a_ok))
          slot_insert(it);
      end
      stlf_pkg::KIND_STORE: begin
        i = 0;
        while (i < slot_cnt) begin
          if (regs_match(slot_base[i], slot_base_ok[i], it.base, it.base_ok) &&
              !ranges_overlap(slot_off[i], slot_size[i], it.off, it.size))
            i++;
          else
            slot_remove(i);
        end
        if (!it.claimed)
          slot_insert(it);
      end
      stlf_pkg::KIND_FLUSH: begin
        slot_cnt = 0;
      end
      default: begin
        slot_drop_reg(it.reg_a, it.reg_a_ok);
      end
    endcase
    return r;
  endfunction

  function automatic dir_row_t mk_row(stlf_pkg::kind_t k, bit c, bit [15:0] ra,
                                      bit ra_ok, bit [15:0] b, bit b_ok, bit [1:0] sz,
                                      bit [31:0] off, bit typed, bit efwd,
                                      bit [15:0] esrc);
    dir_row_t d;
    d.ins.kind     = k;
    d.ins.claimed  = c;
    d.ins.reg_a    = ra;
    d.ins.reg_a_ok = ra_ok;
    d.ins.base     = b;
    d.ins.base_ok  = b_ok;
    d.ins.size     = sz;
    d.ins.off      = off;
    d.exp_typed    = typed;
    d.res.fwd      = efwd;
    d.res.src      = esrc;
    return d;
  endfunction

  function automatic bit [15:0] pick_reg();
    if ($urandom_range(99) < 85)
      return 16'($urandom_range(1, 10));
    return 16'($urandom);
  endfunction

  function automatic instr_t rand_instr();
    instr_t it;
    int     r;
    int     k;
    r = $urandom_range(99);
    if (r < 42)
      it.kind = stlf_pkg::KIND_LOAD;
    else if (r < 77)
      it.kind = stlf_pkg::KIND_STORE;
    else if (r < 83)
      it.kind = stlf_pkg::KIND_FLUSH;
    else
      it.kind = stlf_pkg::KIND_REDEF;
    it.claimed  = ($urandom_range(9) == 0);
    it.reg_a    = pick_reg();
    it.reg_a_ok = ($urandom_range(12) != 0);
    it.base     = ($urandom_range(99) < 80) ? 16'($urandom_range(1, 4)) : 16'($urandom);
    it.base_ok  = ($urandom_range(12) != 0);
    it.size     = 2'($urandom_range(3));
    r = $urandom_range(9);
    if (r < 6)
      it.off = 32'($urandom_range(15) * 4);
    else if (r < 8)
      it.off = 32'hFFFF_FFF0 + 32'($urandom_range(15));
    else
      it.off = $urandom;
    if (it.kind == stlf_pkg::KIND_LOAD || it.kind == stlf_pkg::KIND_STORE) begin
      k = $urandom_range(3);
      if ($urandom_range(9) < 5) begin
        // revisit a known slot; stores sometimes land just beside it
        it.base = rec_base[k];
        it.size = rec_size[k];
        it.off  = rec_off[k];
        if (it.kind == stlf_pkg::KIND_STORE && $urandom_range(2) == 0) begin
          it.off  = rec_off[k] + 32'($urandom_range(8)) - 32'd4;
          it.size = 2'($urandom_range(3));
        end
      end else begin
        rec_base[k] = it.base;
        rec_size[k] = it.size;
        rec_off[k]  = it.off;
      end
    end
    return it;
  endfunction

  task automatic idle_burst();
    repeat ($urandom_range(1, 6)) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
  endtask

  // Hold the word until taken, then queue its expected result
  task automatic send_instr(instr_t it, bit typed, fwd_result_t typed_res);
    fwd_result_t pred;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {4'b0000, it.off, it.size, it.base_ok, it.base, it.reg_a_ok, it.reg_a};
    in_tuser  = {it.claimed, it.kind};
    do @(posedge clk); while (!in_tready);
    pred = forward_predict(it);
    fwd_expect_q.insert(fwd_expect_q.size(), typed ? typed_res : pred);
  endtask

  task automatic note_mismatch(string what, int exp_v, int act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v, act_v);
  endtask

  // Result checker
  always @(posedge clk) begin
    fwd_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (fwd_expect_q.size() == 0) begin
        note_mismatch("unexpected result word", 0, int'({out_tuser, out_tdata}));
      end else begin
        e = fwd_expect_q.pop_front();
        if (out_tuser[0] !== e.fwd)
          note_mismatch("forwarded", int'(e.fwd), int'(out_tuser[0]));
        if (out_tdata !== e.src)
          note_mismatch("forward_src", int'(e.src), int'(out_tdata));
      end
    end
  end

  // Receiver back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if (!quiet && rst_n && $urandom_range(4) == 0) begin
      out_tready = 1'b0;
      stall_left = $urandom_range(1, 6) - 1;
    end else begin
      out_tready = 1'b1;
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    fwd_result_t none;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    out_tready   = 1'b0;
    quiet        = 1'b0;
    stall_left   = 0;
    mismatch_cnt = 0;
    idle_cycles  = 0;
    slot_cnt     = 0;
    none.fwd     = 1'b0;
    none.src     = '0;
    for (int k = 0; k < 4; k++) begin
      rec_base[k] = 16'(k + 1);
      rec_size[k] = SZ_B4;
      rec_off[k]  = 32'(k * 8);
    end

    // kind, claimed, reg_a, reg_a ok, base, base ok,
    // size, offset, typed, forwarded, forward_src
    dir_rows[0]  = mk_row(stlf_pkg::KIND_LOAD, 1'b0, 16'h0001, 1'b1, 16'h0002, 1'b1,
                          SZ_B4, 32'h10, 1'b1, 1'b0, 16'h0); // empty table: miss, slot recorded
    dir_rows[1]  = mk_row(stlf_pkg::KIND_LOAD, 1'b0, 16'h0003, 1'b1, 16'h0002, 1'b1,
                          SZ_B4, 32'h10, 1'b0, 1'b0, 16'h0);
    dir_rows[2]  = mk_row(stlf_pkg::KIND_LOAD, 1'b0, 16'h0001, 1'b1, 16'h0002, 1'b1,
                          SZ_B4, 32'h10, 1'b0, 1'b0, 16'h0); // destination is the value register
    dir_rows[3]  = mk_row(stlf_pkg::KIND_STORE, 1'b0, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1,
                          SZ_B8, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'h0);
    dir_rows[4]  = mk_row(stlf_pkg::KIND_LOAD, 1'b0, 16'h0005, 1'b1, 16'hFFFF, 1'b1,
                          SZ_B8, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0);
    dir_rows[5]  = mk_row(stlf_pkg::KIND_STORE, 1'b0, 16'h0007, 1'b1, 16'hFFFF, 1'b1,
                          SZ_B1, 32'hFFFF_FFF8, 1'b1, 1'b0, 16'h0);
    dir_rows[6]  = mk_row(stlf_pkg::KIND_LOAD, 1'b1, 16'h0009, 1'b1, 16'hFFFF, 1'b1,
                          SZ_B1, 32'hFFFF_FFF8, 1'b1, 1'b0, 16'h0); // claimed hit never forwards
    dir_rows[7]  = mk_row(stlf_pkg::KIND_LOAD, 1'b0, 16'h0009, 1'b1, 16'hFFFF, 1'b1,
                          SZ_B8, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0);
    dir_rows[8]  = mk_row(stlf_pkg::KIND_STORE, 1'b0, 16'h0010, 1'b1, 16'hFFFF, 1'b1,
                          SZ_B2, 32'hFFFF_FFFE, 1'b1, 1'b0, 16'h0); // overlaps the top slot
    dir_rows[9]  = mk_row(stlf_pkg::KIND_LOAD, 1'b0, 16'h0011, 1'b1, 16'hFFFF, 1'b1,
                          SZ_B8, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0);
    dir_rows[10] = mk_row(stlf_pkg::KIND_REDEF, 1'b0, 16'h0010, 1'b1, 16'h0000, 1'b0,
                          SZ_B1, 32'h0, 1'b1, 1'b0, 16'h0);
    dir_rows[11] = mk_row(stlf_pkg::KIND_REDEF, 1'b0, 16'h0011, 1'b0, 16'h0000, 1'b0,
                          SZ_B1, 32'h0, 1'b1, 1'b0, 16'h0); // invalid register drops nothing
    dir_rows[12] = mk_row(stlf_pkg::KIND_LOAD, 1'b0, 16'h0012, 1'b1, 16'hFFFF, 1'b1,
                          SZ_B2, 32'hFFFF_FFFE, 1'b0, 1'b0, 16'h0);
    dir_rows[13] = mk_row(stlf_pkg::KIND_STORE, 1'b0, 16'h0020, 1'b1, 16'h0004, 1'b0,
                          SZ_B4, 32'h20, 1'b1, 1'b0, 16'h0); // invalid base evicts everything
    dir_rows[14] = mk_row(stlf_pkg::KIND_LOAD, 1'b0, 16'h0021, 1'b1, 16'h0004, 1'b0,
                          SZ_B4, 32'h20, 1'b1, 1'b0, 16'h0); // invalid base never matches
    dir_rows[15] = mk_row(stlf_pkg::KIND_STORE, 1'b0, 16'h0000, 1'b0, 16'h0003, 1'b1,
                          SZ_B1, 32'h0, 1'b1, 1'b0, 16'h0); // value register not valid
    dir_rows[16] = mk_row(stlf_pkg::KIND_LOAD, 1'b0, 16'h0004, 1'b1, 16'h0003, 1'b1,
                          SZ_B1, 32'h0, 1'b0, 1'b0, 16'h0);
    dir_rows[17] = mk_row(stlf_pkg::KIND_FLUSH, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0,
                          SZ_B1, 32'h0, 1'b1, 1'b0, 16'h0);
    dir_rows[18] = mk_row(stlf_pkg::KIND_LOAD, 1'b0, 16'h0002, 1'b1, 16'h0002, 1'b1,
                          SZ_B4, 32'h40, 1'b1, 1'b0, 16'h0); // base is the destination: not recorded
    dir_rows[19] = mk_row(stlf_pkg::KIND_LOAD, 1'b0, 16'h0006, 1'b1, 16'h0002, 1'b1,
                          SZ_B4, 32'h40, 1'b0, 1'b0, 16'h0);
    dir_rows[20] = mk_row(stlf_pkg::KIND_STORE, 1'b1, 16'h0008, 1'b1, 16'h0003, 1'b1,
                          SZ_B4, 32'h100, 1'b1, 1'b0, 16'h0); // claimed store is not recorded
    dir_rows[21] = mk_row(stlf_pkg::KIND_LOAD, 1'b0, 16'h0000, 1'b0, 16'h0003, 1'b1,
                          SZ_B4, 32'h100, 1'b0, 1'b0, 16'h0);
    dir_rows[22] = mk_row(stlf_pkg::KIND_FLUSH, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1,
                          SZ_B8, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'h0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int n = 0; n < N_DIRECTED; n++) begin
      if ($urandom_range(3) == 0)
        idle_burst();
      send_instr(dir_rows[n].ins, dir_rows[n].exp_typed, dir_rows[n].res);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= N_RANDOM - N_QUIET);
      if (n == N_RANDOM / 2) begin
        // drain the pipe completely once
        @(negedge clk);
        in_tvalid = 1'b0;
        while (fwd_expect_q.size() != 0)
          @(posedge clk);
      end
      if (!quiet && $urandom_range(3) == 0)
        idle_burst();
      send_instr(rand_instr(), 1'b0, none);
    end
    @(negedge clk);
    in_tvalid = 1'b0;

    while (fwd_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
